// ===== design/rft_pkg.sv =====
// Shared types and constants of the RGB frame transform block.
// Register indexes, geometry codes, shading settings and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rft_pkg;

  // Default frame store dimensions.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W   = 8;
  localparam int COORD_W    = 8;
  localparam int PIXEL_W    = 3 * SAMPLE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_CFG_W  = 9;

  // Item modes.
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_FULL_SCALE    = 3'd2,
    REG_FLOOR_LEVEL   = 3'd3,
    REG_CEILING_LEVEL = 3'd4,
    REG_GEOMETRY      = 3'd5,
    REG_INVERT_ENABLE = 3'd6
  } cfg_reg_e;

  // Output-to-source coordinate mappings.
  typedef enum logic [1:0] {
    GEOM_NONE    = 2'd0,
    GEOM_FLIP_TB = 2'd1,
    GEOM_FLIP_LR = 2'd2,
    GEOM_ROT_CCW = 2'd3
  } geom_e;

  // Register reset values.
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH   = 9'd256;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT  = 9'd256;
  localparam logic [SAMPLE_W-1:0]  RST_FULL_SCALE    = 8'd255;
  localparam logic [SAMPLE_W-1:0]  RST_FLOOR_LEVEL   = 8'd0;
  localparam logic [SAMPLE_W-1:0]  RST_CEILING_LEVEL = 8'd255;

  // Settings of the per-sample shading path.
  typedef struct packed {
    logic                invert;
    logic [SAMPLE_W-1:0] full_scale;
    logic [SAMPLE_W-1:0] floor_level;
    logic [SAMPLE_W-1:0] ceiling_level;
  } shade_cfg_t;

endpackage

`default_nettype wire

// ===== design/rft_addr_map.sv =====
// Coordinate mapping of the RGB frame transform block.
// Clips the frame size, checks the range and maps output to source coordinates.
// Depends on rft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rft_addr_map
  import rft_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic                 mode_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [DIM_CFG_W-1:0] frame_width_i,
  input  logic [DIM_CFG_W-1:0] frame_height_i,
  input  geom_e                geometry_i,
  output logic [XW-1:0]        src_col_o,
  output logic [YW-1:0]        src_row_o,
  output logic                 hit_o
);

  localparam int WBits = $clog2(MAX_WIDTH + 1);
  localparam int HBits = $clog2(MAX_HEIGHT + 1);
  localparam int WhBits = (WBits > HBits) ? WBits : HBits;
  localparam int DimW = (WhBits > DIM_CFG_W) ? WhBits : DIM_CFG_W;
  localparam logic [DimW-1:0] MaxW = DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] MaxH = DimW'(MAX_HEIGHT);
  localparam logic [DimW-1:0] One  = DimW'(1);

  logic [DimW-1:0] fw, fh, w_eff, h_eff, ow, oh;
  logic [DimW-1:0] col_x, row_x, sc, sr;

  // Clip the configured size to the store dimensions.
  assign fw    = DimW'(frame_width_i);
  assign fh    = DimW'(frame_height_i);
  assign w_eff = (fw > MaxW) ? MaxW : fw;
  assign h_eff = (fh > MaxH) ? MaxH : fh;
  assign col_x = DimW'(col_i);
  assign row_x = DimW'(row_i);

  // Output frame size and source coordinate for each geometry.
  always_comb begin
    ow = w_eff;
    oh = h_eff;
    sc = col_x;
    sr = row_x;
    case (geometry_i)
      GEOM_FLIP_TB: begin
        sr = h_eff - One - row_x;
      end
      GEOM_FLIP_LR: begin
        sc = w_eff - One - col_x;
      end
      GEOM_ROT_CCW: begin
        ow = h_eff;
        oh = w_eff;
        sc = w_eff - One - row_x;
        sr = col_x;
      end
      default: begin
        sc = col_x;
        sr = row_x;
      end
    endcase
  end

  // A store always addresses the source frame directly.
  always_comb begin
    if (mode_i == MODE_STORE) begin
      hit_o     = (col_x < w_eff) && (row_x < h_eff);
      src_col_o = col_x[XW-1:0];
      src_row_o = row_x[YW-1:0];
    end else begin
      hit_o     = (col_x < ow) && (row_x < oh);
      src_col_o = sc[XW-1:0];
      src_row_o = sr[YW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/rft_frame_mem.sv =====
// Pixel frame store of the RGB frame transform block.
// One synchronous write port and one registered read port.
// Depends on rft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rft_frame_mem
  import rft_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [PIXEL_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [PIXEL_W-1:0] rd_data_o
);

  logic [PIXEL_W-1:0] mem_q [DEPTH];
  logic [PIXEL_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/rft_shade.sv =====
// Per-sample shading of the RGB frame transform block.
// Optional inversion, then floor clamp, then ceiling clamp.
// Depends on rft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rft_shade
  import rft_pkg::*;
(
  input  shade_cfg_t          cfg_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SAMPLE_W-1:0] sample_o
);

  logic [SAMPLE_W-1:0] inv, floored;

  // Inversion wraps modulo the sample range.
  assign inv     = cfg_i.invert ? (cfg_i.full_scale - sample_i) : sample_i;
  // The ceiling clamp comes last, so it wins when floor exceeds ceiling.
  assign floored  = (inv < cfg_i.floor_level) ? cfg_i.floor_level : inv;
  assign sample_o = (floored > cfg_i.ceiling_level) ? cfg_i.ceiling_level : floored;

endmodule

`default_nettype wire

// ===== design/rgb_frame_transform.sv =====
// Top level of the RGB frame transform block: RGB frame store with read-side
// geometry mapping, inversion and clamping. Depends on rft_pkg, rft_addr_map,
// rft_frame_mem and rft_shade.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  mode, col, row, red/green/blue in
//   output   out        out_valid_o / out_stall_i red/green/blue out, out_of_range
//   config   in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle when the output side keeps up. A read beat
// passes the mapping register, loaded at acceptance, then the frame store read
// register and the output register, which shows its result. A store beat writes
// the frame store in the cycle after acceptance and gives no result; a read always
// sees earlier stores. Reset clears the valid bits and the configuration registers,
// not the data registers or the frame store. Stalls back up stage by stage.
`timescale 1ns / 1ps
`default_nettype none

module rgb_frame_transform
  import rft_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [SAMPLE_W-1:0]   red_in_i,
  input  logic [SAMPLE_W-1:0]   green_in_i,
  input  logic [SAMPLE_W-1:0]   blue_in_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   red_out_o,
  output logic [SAMPLE_W-1:0]   green_out_o,
  output logic [SAMPLE_W-1:0]   blue_out_o,
  output logic                  out_of_range_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] RowPitch = AW'(MAX_WIDTH);

  // Configuration registers.
  logic [DIM_CFG_W-1:0] frame_width_q, frame_height_q;
  logic [SAMPLE_W-1:0]  full_scale_q, floor_level_q, ceiling_level_q;
  geom_e                geometry_q;
  logic                 invert_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= RST_FRAME_WIDTH;
      frame_height_q  <= RST_FRAME_HEIGHT;
      full_scale_q    <= RST_FULL_SCALE;
      floor_level_q   <= RST_FLOOR_LEVEL;
      ceiling_level_q <= RST_CEILING_LEVEL;
      geometry_q      <= GEOM_NONE;
      invert_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FULL_SCALE:    full_scale_q    <= cfg_data_i[SAMPLE_W-1:0];
        REG_FLOOR_LEVEL:   floor_level_q   <= cfg_data_i[SAMPLE_W-1:0];
        REG_CEILING_LEVEL: ceiling_level_q <= cfg_data_i[SAMPLE_W-1:0];
        REG_GEOMETRY:      geometry_q      <= geom_e'(cfg_data_i[1:0]);
        REG_INVERT_ENABLE: invert_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Coordinate mapping ahead of the first stage.
  logic [XW-1:0] map_col;
  logic [YW-1:0] map_row;
  logic          map_hit;

  rft_addr_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_map (
    .mode_i         (mode_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .geometry_i     (geometry_q),
    .src_col_o      (map_col),
    .src_row_o      (map_row),
    .hit_o          (map_hit)
  );

  // Map stage registers.
  logic               mode_a_q, hit_a_q;
  logic [XW-1:0]      col_a_q;
  logic [YW-1:0]      row_a_q;
  logic [PIXEL_W-1:0] pix_a_q;

  // Pipeline control: map stage, memory read stage, output register.
  logic v_a_q, v_r_q, v_o_q;
  logic ready_o, ready_r, adv_a, ready_a, accept, read_a;

  assign read_a     = (mode_a_q == MODE_READ);
  assign ready_o    = !v_o_q || !out_stall_i;
  assign ready_r    = !v_r_q || ready_o;
  assign adv_a      = v_a_q && (!read_a || ready_r);
  assign ready_a    = !v_a_q || adv_a;
  assign in_stall_o = !ready_a;
  assign accept     = in_valid_i && ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (ready_a) begin
      v_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_a_q <= mode_i;
      hit_a_q  <= map_hit;
      col_a_q  <= map_col;
      row_a_q  <= map_row;
      pix_a_q  <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // Frame store access.
  logic [AW-1:0]      addr_a;
  logic [PIXEL_W-1:0] rd_data;

  assign addr_a = AW'(row_a_q) * RowPitch + AW'(col_a_q);

  rft_frame_mem #(
    .DEPTH (Depth)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .wr_en_i   (adv_a && !read_a && hit_a_q),
    .wr_addr_i (addr_a),
    .wr_data_i (pix_a_q),
    .rd_en_i   (adv_a && read_a && hit_a_q),
    .rd_addr_i (addr_a),
    .rd_data_o (rd_data)
  );

  // Read stage: valid bit and range flag beside the memory data register.
  logic oor_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_r_q <= 1'b0;
    end else if (adv_a && read_a) begin
      v_r_q <= 1'b1;
    end else if (ready_o) begin
      v_r_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && read_a) begin
      oor_r_q <= !hit_a_q;
    end
  end

  // Shading of the three samples.
  shade_cfg_t          shade_cfg;
  logic [SAMPLE_W-1:0] red_sh, green_sh, blue_sh;

  assign shade_cfg = '{
    invert:        invert_enable_q,
    full_scale:    full_scale_q,
    floor_level:   floor_level_q,
    ceiling_level: ceiling_level_q
  };

  rft_shade u_shade_red (
    .cfg_i    (shade_cfg),
    .sample_i (rd_data[3*SAMPLE_W-1:2*SAMPLE_W]),
    .sample_o (red_sh)
  );

  rft_shade u_shade_green (
    .cfg_i    (shade_cfg),
    .sample_i (rd_data[2*SAMPLE_W-1:SAMPLE_W]),
    .sample_o (green_sh)
  );

  rft_shade u_shade_blue (
    .cfg_i    (shade_cfg),
    .sample_i (rd_data[SAMPLE_W-1:0]),
    .sample_o (blue_sh)
  );

  // Output register.
  logic [SAMPLE_W-1:0] red_o_q, green_o_q, blue_o_q;
  logic                oor_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
    end else if (ready_o) begin
      v_o_q <= v_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && v_r_q) begin
      red_o_q   <= oor_r_q ? '0 : red_sh;
      green_o_q <= oor_r_q ? '0 : green_sh;
      blue_o_q  <= oor_r_q ? '0 : blue_sh;
      oor_o_q   <= oor_r_q;
    end
  end

  assign out_valid_o    = v_o_q;
  assign red_out_o      = red_o_q;
  assign green_out_o    = green_o_q;
  assign blue_out_o     = blue_o_q;
  assign out_of_range_o = oor_o_q;

  // A new result appears only when the read stage held one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v_o_q) |-> $past(v_r_q))
    else $error("output beat without a read stage entry");

  // Only a read waiting on the read stage can hold off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_a_q && read_a && v_r_q && v_o_q && out_stall_i))
    else $error("input stalled without a blocked read");

  // A blocked read stage keeps its memory data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_r_q && v_o_q && out_stall_i) |=> (v_r_q && $stable(rd_data) && $stable(oor_r_q)))
    else $error("read stage data lost under stall");

  // An out-of-range result carries zero samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_o_q && oor_o_q) |-> (red_o_q == '0 && green_o_q == '0 && blue_o_q == '0))
    else $error("out-of-range result with nonzero samples");

endmodule

`default_nettype wire

// ===== test/rgb_frame_transform_test.sv =====
// Self-checking testbench of rgb_frame_transform: stores pixels, reads them back
// through every geometry, inversion and clamp setting and checks each result beat
// against an in-bench frame model. Depends on rft_pkg and rgb_frame_transform.
`timescale 1ns / 1ps

module rgb_frame_transform_test;
  import rft_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BEATS = 700;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic                mode;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_beat_t;

  typedef struct {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                out_of_range;
  } pixel_result_t;

  // Block ports.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i         = MODE_STORE;
  logic [COORD_W-1:0]    col_i          = '0;
  logic [COORD_W-1:0]    row_i          = '0;
  logic [SAMPLE_W-1:0]   red_in_i       = '0;
  logic [SAMPLE_W-1:0]   green_in_i     = '0;
  logic [SAMPLE_W-1:0]   blue_in_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [SAMPLE_W-1:0]   red_out_o;
  logic [SAMPLE_W-1:0]   green_out_o;
  logic [SAMPLE_W-1:0]   blue_out_o;
  logic                  out_of_range_o;

  // Frame model: register copies and pixel contents.
  logic [DIM_CFG_W-1:0] cfg_width      = RST_FRAME_WIDTH;
  logic [DIM_CFG_W-1:0] cfg_height     = RST_FRAME_HEIGHT;
  logic [SAMPLE_W-1:0]  cfg_full_scale = RST_FULL_SCALE;
  logic [SAMPLE_W-1:0]  cfg_floor      = RST_FLOOR_LEVEL;
  logic [SAMPLE_W-1:0]  cfg_ceiling    = RST_CEILING_LEVEL;
  geom_e                cfg_geom       = GEOM_NONE;
  logic                 cfg_invert     = 1'b0;
  logic [PIXEL_W-1:0]   frame_pixels [MAX_W*MAX_H];
  // Pixels already stored by queued beats, so that no read hits an unwritten entry.
  bit                   queued_written [MAX_W*MAX_H];

  pixel_beat_t   pending_beats[$];
  pixel_result_t expected_pixels[$];
  int            beats_queued   = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  // Handshake pacing.
  bit tx_taken      = 1'b0;
  bit tx_gaps_on    = 1'b0;
  bit rx_gaps_on    = 1'b0;
  int tx_gap_left   = 0;
  int rx_gap_left   = 0;
  int rx_hold_left  = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  rgb_frame_transform u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Effective frame and output dimensions under the current settings.
  function automatic int eff_width();
    return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height > MAX_H) ? MAX_H : int'(cfg_height);
  endfunction

  function automatic int out_width();
    return (cfg_geom == GEOM_ROT_CCW) ? eff_height() : eff_width();
  endfunction

  function automatic int out_height();
    return (cfg_geom == GEOM_ROT_CCW) ? eff_width() : eff_height();
  endfunction

  // Maps an output coordinate to its source pixel; returns 0 when it lies outside.
  function automatic bit map_out_to_src(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                                        output logic [COORD_W-1:0] sc,
                                        output logic [COORD_W-1:0] sr);
    sc = c;
    sr = r;
    if (int'(c) >= out_width() || int'(r) >= out_height()) return 1'b0;
    case (cfg_geom)
      GEOM_FLIP_TB: sr = COORD_W'(eff_height() - 1 - int'(r));
      GEOM_FLIP_LR: sc = COORD_W'(eff_width() - 1 - int'(c));
      GEOM_ROT_CCW: begin
        sc = COORD_W'(eff_width() - 1 - int'(r));
        sr = c;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Inversion with 8-bit wrap, then floor clamp, then ceiling clamp.
  function automatic logic [SAMPLE_W-1:0] shade_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] v;
    v = s;
    if (cfg_invert) v = cfg_full_scale - s;
    if (v < cfg_floor) v = cfg_floor;
    if (v > cfg_ceiling) v = cfg_ceiling;
    return v;
  endfunction

  // Applies one accepted beat to the frame model; a read yields one expected pixel.
  task automatic transform_beat(input pixel_beat_t b);
    logic [COORD_W-1:0] sc, sr;
    logic [PIXEL_W-1:0] px;
    pixel_result_t      res;
    if (b.mode == MODE_STORE) begin
      if (int'(b.col) < eff_width() && int'(b.row) < eff_height())
        frame_pixels[{b.row, b.col}] = {b.red, b.green, b.blue};
    end else begin
      if (map_out_to_src(b.col, b.row, sc, sr)) begin
        px = frame_pixels[{sr, sc}];
        res.red          = shade_sample(px[23:16]);
        res.green        = shade_sample(px[15:8]);
        res.blue         = shade_sample(px[7:0]);
        res.out_of_range = 1'b0;
      end else begin
        res = '{red: '0, green: '0, blue: '0, out_of_range: 1'b1};
      end
      expected_pixels.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input side: take the accepted beat into the model at the rising edge.
  always @(posedge clk_i) begin
    tx_taken = in_valid_i && !in_stall_o;
    if (tx_taken) transform_beat(pending_beats.pop_front());
  end

  // Input driver: a stalled beat holds; otherwise idle for a gap or offer the next one.
  always @(negedge clk_i) begin
    if (!(in_valid_i && !tx_taken)) begin
      if (tx_taken && tx_gaps_on) tx_gap_left = pick_gap();
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid_i <= 1'b1;
        mode_i     <= pending_beats[0].mode;
        col_i      <= pending_beats[0].col;
        row_i      <= pending_beats[0].row;
        red_in_i   <= pending_beats[0].red;
        green_in_i <= pending_beats[0].green;
        blue_in_i  <= pending_beats[0].blue;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: a requested long hold-off first, then random stalls.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_gap_left == 0) rx_gap_left = rx_gaps_on ? pick_gap() : 0;
      if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Output monitor: compare each result beat with the oldest expected pixel.
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result beat with no read pending");
      end else begin
        want = expected_pixels.pop_front();
        if (red_out_o !== want.red)
          report_mismatch($sformatf("red: expected %0d, got %0d", want.red, red_out_o));
        if (green_out_o !== want.green)
          report_mismatch($sformatf("green: expected %0d, got %0d", want.green, green_out_o));
        if (blue_out_o !== want.blue)
          report_mismatch($sformatf("blue: expected %0d, got %0d", want.blue, blue_out_o));
        if (out_of_range_o !== want.out_of_range)
          report_mismatch($sformatf("out_of_range: expected %0b, got %0b",
                                    want.out_of_range, out_of_range_o));
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Waits until every beat is accepted and every result has come, plus pipeline slack.
  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_FRAME_WIDTH:   cfg_width      = data;
      REG_FRAME_HEIGHT:  cfg_height     = data;
      REG_FULL_SCALE:    cfg_full_scale = data[SAMPLE_W-1:0];
      REG_FLOOR_LEVEL:   cfg_floor      = data[SAMPLE_W-1:0];
      REG_CEILING_LEVEL: cfg_ceiling    = data[SAMPLE_W-1:0];
      REG_GEOMETRY:      cfg_geom       = geom_e'(data[1:0]);
      REG_INVERT_ENABLE: cfg_invert     = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Writes every register once the block is idle, plus a write to the unused index.
  task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input logic [8:0] fs,
                           input logic [8:0] fl, input logic [8:0] cl, input logic [8:0] gm,
                           input logic [8:0] inv);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_FLOOR_LEVEL, fl);
    write_reg(REG_CEILING_LEVEL, cl);
    write_reg(REG_GEOMETRY, gm);
    write_reg(REG_INVERT_ENABLE, inv);
    write_reg(REG_UNUSED, 9'($urandom));
  endtask

  task automatic queue_store(input int c, input int r, input logic [PIXEL_W-1:0] rgb);
    pixel_beat_t b;
    b = '{mode: MODE_STORE, col: COORD_W'(c), row: COORD_W'(r),
          red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0]};
    if (c < eff_width() && r < eff_height()) queued_written[{b.row, b.col}] = 1'b1;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Queues a read; a source pixel never stored gets a store queued ahead of it.
  task automatic queue_read(input int c, input int r);
    pixel_beat_t        b;
    logic [COORD_W-1:0] sc, sr;
    if (map_out_to_src(COORD_W'(c), COORD_W'(r), sc, sr) && !queued_written[{sr, sc}])
      queue_store(int'(sc), int'(sr), PIXEL_W'($urandom));
    b = '{mode: MODE_READ, col: COORD_W'(c), row: COORD_W'(r),
          red: SAMPLE_W'($urandom), green: SAMPLE_W'($urandom), blue: SAMPLE_W'($urandom)};
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Mostly small frames; now and then the extremes, oversize and zero.
  function automatic logic [8:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 9'($urandom_range(1, 8));
    if (r < 16) return 9'($urandom_range(9, 32));
    if (r == 16) return 9'd256;
    if (r == 17) return 9'd1;
    if (r == 18) return 9'($urandom_range(257, 511));
    return 9'd0;
  endfunction

  // A level with a random ninth bit that the register drops.
  function automatic logic [8:0] pick_level(input logic [SAMPLE_W-1:0] usual);
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = usual;
      2: v = SAMPLE_W'($urandom);
      default: v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
    return {1'($urandom), v};
  endfunction

  // One random phase: fill small frames, then a mix of stores, reads and noise.
  task automatic run_random_phase(input bit pressure);
    int n, k, w, h;
    set_frame(pick_dim(), pick_dim(), pick_level(RST_FULL_SCALE), pick_level(RST_FLOOR_LEVEL),
              pick_level(RST_CEILING_LEVEL), {7'($urandom), 2'($urandom)},
              {8'($urandom), 1'($urandom)});
    tx_gaps_on = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
    rx_gaps_on = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (pressure) hold_requests++;
    w = eff_width();
    h = eff_height();
    if (w * h > 0 && w * h <= 48) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          queue_store(c, r, PIXEL_W'($urandom));
    end
    n = pressure ? 80 : $urandom_range(30, 70);
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 25 && w > 0 && h > 0)
        queue_store($urandom_range(0, w - 1), $urandom_range(0, h - 1), PIXEL_W'($urandom));
      else if (k < 30)
        queue_store($urandom_range(0, 255), $urandom_range(0, 255), PIXEL_W'($urandom));
      else if (k < 88 && out_width() > 0 && out_height() > 0)
        queue_read($urandom_range(0, out_width() - 1), $urandom_range(0, out_height() - 1));
      else
        queue_read($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int start_count;
    int phase_idx;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Plain 2x3 frame: extreme samples, reads in range and past every edge.
    set_frame(9'd2, 9'd3, 9'd255, 9'd0, 9'd255, 9'(GEOM_NONE), 9'd0);
    queue_store(0, 0, 24'h000000);
    queue_store(1, 0, 24'hFFFFFF);
    queue_store(0, 1, 24'h123456);
    queue_store(1, 1, 24'hFF00FF);
    queue_store(0, 2, 24'h00FF00);
    queue_store(1, 2, 24'h80017F);
    queue_store(2, 0, 24'hAAAAAA);
    queue_store(0, 3, 24'h555555);
    queue_read(0, 0);
    queue_read(1, 2);
    queue_read(2, 0);
    queue_read(0, 3);
    queue_read(255, 255);

    // Each geometry mapping, the rotation with its swapped output size.
    set_frame(9'd2, 9'd3, 9'd255, 9'd0, 9'd255, 9'(GEOM_FLIP_TB), 9'd0);
    queue_read(0, 0);
    queue_read(1, 1);
    set_frame(9'd2, 9'd3, 9'd255, 9'd0, 9'd255, 9'(GEOM_FLIP_LR), 9'd0);
    queue_read(0, 2);
    queue_read(1, 0);
    set_frame(9'd2, 9'd3, 9'd255, 9'd0, 9'd255, 9'(GEOM_ROT_CCW), 9'd0);
    queue_read(2, 1);
    queue_read(0, 0);
    queue_read(0, 2);
    queue_read(3, 0);

    // Inversion that wraps for samples above full scale.
    set_frame(9'd2, 9'd3, 9'd100, 9'd0, 9'd255, 9'(GEOM_NONE), 9'd1);
    queue_read(1, 0);
    queue_read(0, 0);

    // Floor above ceiling: the ceiling wins.
    set_frame(9'd2, 9'd3, 9'd255, 9'd200, 9'd50, 9'(GEOM_NONE), 9'd0);
    queue_read(0, 1);

    // Zero width: everything lies outside and stores are dropped.
    set_frame(9'd0, 9'd3, 9'd255, 9'd0, 9'd255, 9'(GEOM_NONE), 9'd0);
    queue_store(0, 0, 24'hC0FFEE);
    queue_read(0, 0);

    // Oversize settings act as the maximum frame.
    set_frame(9'd511, 9'd300, 9'd255, 9'd0, 9'd255, 9'(GEOM_NONE), 9'd0);
    queue_store(255, 255, 24'h7F80FE);
    queue_read(255, 255);

    // Random phases; the fourth one holds off the output so the block backs up.
    start_count = beats_queued;
    phase_idx   = 0;
    while (beats_queued - start_count < RANDOM_BEATS) begin
      run_random_phase(phase_idx == 3);
      phase_idx++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
